@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_pkg
// Shared constants and types of the windowed moving average.
// ----------------------------------------------------------------------------
package wma_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DEF_WINDOW = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV
	} state_t;

endpackage

@@ design/wma_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module wma_ram #(
	parameter int WIDTH = wma_pkg::SAMPLE_W,
	parameter int DEPTH = wma_pkg::DEF_WINDOW
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/wma_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wma_div #(
	parameter int SUM_W = 22,
	parameter int CNT_W = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SUM_W-1:0]              dividend,
	input  logic [CNT_W-1:0]              divisor,
	output logic                          busy,
	output logic [wma_pkg::SAMPLE_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic             busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, num_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			busy_q <= (step_q != STEP_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	// The average never exceeds the largest sample, so the low bits carry it all.
	assign quotient = num_q[wma_pkg::SAMPLE_W-1:0];

endmodule

@@ design/windowed_moving_average.sv @@
`timescale 1ns / 1ps
// An accepted sample goes through the UPD state, the serial divider and the output register
// before its result shows on the master side. No new sample is taken until the result of
//   the last one is loaded; the divider takes one quotient bit per cycle over the SUM_W-bit sum.
// Reset: arst_n clears the running sum, write index, fill count, FSM and output valid.
//   The sample store needs no clearing pass: while the fill count is below WINDOW the
//   replaced entry was never written and counts as zero.
// ----------------------------------------------------------------------------
// windowed_moving_average
// Moving average over the last WINDOW 16-bit samples, kept in a ring RAM.
// ----------------------------------------------------------------------------
module windowed_moving_average #(
	parameter int WINDOW = wma_pkg::DEF_WINDOW
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] average
	output logic [0:0]  m_axis_tuser    // [0] window_full
);

	localparam int SW    = wma_pkg::SAMPLE_W;
	localparam int IDX_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SW + $clog2(WINDOW);

	wma_pkg::state_t state_q, state_d;

	// Architectural state
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    sample_q;

	// Output register
	logic             out_valid_q;
	logic [SW-1:0]    avg_q;
	logic             full_q;

	// Datapath
	logic             in_xfer;
	logic             out_free;
	logic             full_now;
	logic [SW-1:0]    old_sample;
	logic [SW-1:0]    ram_rdata;
	logic [SUM_W-1:0] sum_next;
	logic [IDX_W-1:0] idx_next;
	logic [CNT_W-1:0] cnt_next;
	logic             upd;
	logic             load_out;
	logic             div_busy;
	logic [SW-1:0]    div_quot;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign full_now = (cnt_q == CNT_W'(WINDOW));

	// Until the ring has wrapped once the replaced entry was never written and is taken as zero.
	assign old_sample = full_now ? ram_rdata : '0;
	assign sum_next   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
	assign idx_next   = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + IDX_W'(1);
	assign cnt_next   = full_now ? cnt_q : cnt_q + CNT_W'(1);

	// Ring store: read the oldest entry on the transfer, write the new sample
	// back to the same entry in the cycle after. Only one sample is in flight, so
	// no read can overlap a pending write.
	wma_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (upd),
		.waddr (idx_q),
		.wdata (sample_q),
		.re    (in_xfer),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Sum divided by the updated fill count, truncated.
	wma_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (upd),
		.dividend (sum_next),
		.divisor  (cnt_next),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		upd           = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			wma_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = wma_pkg::ST_UPD;
				end
			end
			wma_pkg::ST_UPD: begin
				// RAM data is valid now: fold it into the sum and store the sample.
				upd     = 1'b1;
				state_d = wma_pkg::ST_DIV;
			end
			wma_pkg::ST_DIV: begin
				// Hold the quotient until the output register can take it.
				if (!div_busy && out_free) begin
					load_out = 1'b1;
					state_d  = wma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wma_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
		end else if (upd) begin
			sum_q <= sum_next;
			idx_q <= idx_next;
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q  <= div_quot;
			full_q <= full_now;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = avg_q;
	assign m_axis_tuser[0] = full_q;

endmodule

@@ design/wma_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_checker
// Port-level checks of the moving average, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wma_checker #(
	parameter int WINDOW = wma_pkg::DEF_WINDOW
) (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [0:0] m_axis_tuser
);

	localparam int CNT_W = $clog2(WINDOW + 1);

	logic             in_xfer;
	logic             out_xfer;
	logic [2:0]       pend_q;
	logic [CNT_W-1:0] seen_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Track samples taken but not yet delivered, and results delivered so far, up to WINDOW.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			seen_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_xfer) - 3'(out_xfer);
			if (out_xfer && seen_q != CNT_W'(WINDOW)) begin
				seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

	`ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready, "sample taken while one is in work")
	`ASSERT_ALWAYS(a_pending_bound, pend_q <= 3'd2, "more than two samples pending")
	`ASSERT_IMPL(a_not_full_early, out_xfer && seen_q < CNT_W'(WINDOW - 1), !m_axis_tuser[0], "window full too early")
	`ASSERT_IMPL(a_full_late, out_xfer && seen_q >= CNT_W'(WINDOW - 1), m_axis_tuser[0], "window full missing")
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

endmodule

bind windowed_moving_average wma_checker #(.WINDOW(WINDOW)) u_wma_checker (.*);
